@@ sv/csab_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite blitter package
// Shared types, register indexes and constants of the clipped alpha blitter.
// ----------------------------------------------------------------------------
package csab_pkg;

   // Fixed field widths.
   localparam int unsigned BYTES_PER_PIXEL = 4;
   localparam int unsigned BPP_SHIFT       = $clog2(BYTES_PER_PIXEL);
   localparam int unsigned ADDR_W          = 28;
   localparam int unsigned COLOR_W         = 24;
   localparam int unsigned DIM_W           = 13;
   localparam int unsigned PITCH_W         = 17;
   localparam int unsigned CSR_INDEX_W     = 3;
   localparam int unsigned CSR_DATA_W      = 17;

   // Result word: address then color, padded to whole bytes.
   localparam int unsigned RSP_DATA_W      = ADDR_W + COLOR_W;
   localparam int unsigned RSP_TDATA_W     = ((RSP_DATA_W + 7) / 8) * 8;

   // Rounded divide by 255: floor((2*num + 255) / 510) as a reciprocal
   // multiply; exact for every dividend below 132626, which covers the
   // whole range of the blend sum.
   localparam logic [17:0] BLEND_RECIP = 18'd131587;
   localparam int unsigned BLEND_SHIFT = 26;

   // Register reset values.
   localparam logic [12:0] DEST_WIDTH_RST    = 13'd640;
   localparam logic [12:0] DEST_HEIGHT_RST   = 13'd480;
   localparam logic [16:0] DEST_PITCH_RST    = 17'd2560;
   localparam logic [12:0] BITMAP_WIDTH_RST  = 13'd64;
   localparam logic [12:0] BITMAP_HEIGHT_RST = 13'd64;

   // Register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEST_WIDTH    = 3'd0,
      CSR_DEST_HEIGHT   = 3'd1,
      CSR_DEST_PITCH    = 3'd2,
      CSR_BITMAP_WIDTH  = 3'd3,
      CSR_BITMAP_HEIGHT = 3'd4,
      CSR_POS_X         = 3'd5,
      CSR_POS_Y         = 3'd6
   } csr_index_type;

   // Configuration register file contents.
   typedef struct packed {
      logic        [12:0] dest_width;
      logic        [12:0] dest_height;
      logic        [16:0] dest_pitch;
      logic        [12:0] bitmap_width;
      logic        [12:0] bitmap_height;
      logic signed [12:0] pos_x;
      logic signed [12:0] pos_y;
   } cfg_type;

   // Pipeline stage load enables.
   typedef struct packed {
      logic s1_en;
      logic s2_en;
      logic s3_en;
   } adv_type;

   // First-stage pixel record: colors plus mapped screen place.
   typedef struct packed {
      logic [7:0]  alpha;
      logic [23:0] src_rgb;
      logic [23:0] dst_rgb;
      logic        on_screen;
      logic        last;
      logic [12:0] scr_x;
      logic [12:0] scr_y;
   } pix_type;

endpackage
`default_nettype wire

@@ sv/clipped_alpha_sprite_blit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Clipped alpha sprite blitter
// Maps streamed bitmap pixels to the screen, clips them and blends each kept
// pixel over the destination pixel.
// ----------------------------------------------------------------------------
// Channel   Direction  Carries
// req_*     in         source and destination pixels, first-pixel flag
// rsp_*     out        write enable, byte address, blended color, last flag
// csr_*     in         register index and data
//
// One pixel is accepted every cycle unless a stall holds the pipeline; each pixel
// passes the walker stage, the product stage and the output register.
// Reset clears the counters and the pipeline valids and loads the registers' reset values.
// A stall on rsp_tready holds the output register; earlier stages keep
// filling until the pipeline is full.
// ----------------------------------------------------------------------------
module clipped_alpha_sprite_blit
   import csab_pkg::*;
#(
   parameter int unsigned MAX_DIM = 4096
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // tdata: src_pixel[31:0], dst_pixel[63:32]
   input  wire logic [63:0]            req_tdata,
   // tuser: first
   input  wire logic                   req_tuser,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // tdata: dest_address[27:0], blended_color[51:28], zero padding[55:52]
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // tuser: write_enable
   output logic                        rsp_tuser,
   output logic                        rsp_tlast,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg;
   pix_type s1;
   adv_type adv;
   logic    accept;
   logic    v1_ff, v2_ff, v3_ff;
   logic    v1_in, v2_in, v3_in;

   logic [ADDR_W-1:0]  row_ofs_ff, row_ofs_in;
   logic [12:0]        x2_ff;
   logic               inside2_ff, last2_ff;
   logic [7:0]         red, green, blue;
   logic [ADDR_W-1:0]  addr_in, addr_ff;
   logic [COLOR_W-1:0] color_in, color_ff;
   logic               we_ff, last_ff;

   // Stage enables: a stage loads when the one after it is free or moving.
   assign adv.s3_en = !v3_ff || rsp_tready;
   assign adv.s2_en = !v2_ff || adv.s3_en;
   assign adv.s1_en = !v1_ff || adv.s2_en;
   assign req_tready = adv.s1_en;
   assign accept     = req_tvalid && req_tready;

   // Valid flags of the three stages.
   assign v1_in = adv.s1_en ? req_tvalid : v1_ff;
   assign v2_in = adv.s2_en ? v1_ff : v2_ff;
   assign v3_in = adv.s3_en ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   csab_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   csab_walk #(
      .MAX_DIM (MAX_DIM)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .load      (adv.s1_en),
      .src_pixel (req_tdata[31:0]),
      .dst_pixel (req_tdata[63:32]),
      .first     (req_tuser),
      .cfg       (cfg),
      .s1        (s1)
   );

   // Per-channel blend, weighted sum registered at stage two.
   csab_chan u_red (
      .clock (clock),
      .load  (adv.s2_en),
      .alpha (s1.alpha),
      .src   (s1.src_rgb[23:16]),
      .dst   (s1.dst_rgb[23:16]),
      .blend (red)
   );

   csab_chan u_green (
      .clock (clock),
      .load  (adv.s2_en),
      .alpha (s1.alpha),
      .src   (s1.src_rgb[15:8]),
      .dst   (s1.dst_rgb[15:8]),
      .blend (green)
   );

   csab_chan u_blue (
      .clock (clock),
      .load  (adv.s2_en),
      .alpha (s1.alpha),
      .src   (s1.src_rgb[7:0]),
      .dst   (s1.dst_rgb[7:0]),
      .blend (blue)
   );

   // Stage two of the address: row times pitch.
   assign row_ofs_in = ADDR_W'(30'(s1.scr_y) * 30'(cfg.dest_pitch));

   always_ff @(posedge clock) begin
      if (adv.s2_en) begin
         row_ofs_ff <= row_ofs_in;
         x2_ff      <= s1.scr_x;
         inside2_ff <= s1.on_screen;
         last2_ff   <= s1.last;
      end
   end

   // Output stage; clipped pixels report zero address and color.
   assign addr_in  = inside2_ff ? row_ofs_ff + (ADDR_W'(x2_ff) << BPP_SHIFT) : '0;
   assign color_in = inside2_ff ? {red, green, blue} : '0;

   always_ff @(posedge clock) begin
      if (adv.s3_en) begin
         addr_ff  <= addr_in;
         color_ff <= color_in;
         we_ff    <= inside2_ff;
         last_ff  <= last2_ff;
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-RSP_DATA_W){1'b0}}, color_ff, addr_ff};
   assign rsp_tuser  = we_ff;
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire

@@ sv/csab_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite blitter configuration registers
// Holds destination, bitmap and position settings written over the CSR port.
// ----------------------------------------------------------------------------
module csab_cfg
   import csab_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes complete in the cycle they are offered.
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Register write decode; unused indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEST_WIDTH:    cfg_in.dest_width    = csr_wdata[12:0];
            CSR_DEST_HEIGHT:   cfg_in.dest_height   = csr_wdata[12:0];
            CSR_DEST_PITCH:    cfg_in.dest_pitch    = csr_wdata[16:0];
            CSR_BITMAP_WIDTH:  cfg_in.bitmap_width  = csr_wdata[12:0];
            CSR_BITMAP_HEIGHT: cfg_in.bitmap_height = csr_wdata[12:0];
            CSR_POS_X:         cfg_in.pos_x         = $signed(csr_wdata[12:0]);
            CSR_POS_Y:         cfg_in.pos_y         = $signed(csr_wdata[12:0]);
            default:           cfg_in               = cfg_ff;
         endcase
      end
   end

   // Register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_width    <= DEST_WIDTH_RST;
         cfg_ff.dest_height   <= DEST_HEIGHT_RST;
         cfg_ff.dest_pitch    <= DEST_PITCH_RST;
         cfg_ff.bitmap_width  <= BITMAP_WIDTH_RST;
         cfg_ff.bitmap_height <= BITMAP_HEIGHT_RST;
         cfg_ff.pos_x         <= '0;
         cfg_ff.pos_y         <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

@@ sv/csab_walk.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite blitter bitmap walker
// Tracks the source column and row, maps each pixel to the screen, clips it
// and loads the first pipeline stage.
// ----------------------------------------------------------------------------
module csab_walk
   import csab_pkg::*;
#(
   parameter int unsigned MAX_DIM = 4096
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic        load,
   input  wire logic [31:0] src_pixel,
   input  wire logic [31:0] dst_pixel,
   input  wire logic        first,
   input  wire cfg_type     cfg,
   output pix_type          s1
);

   localparam int unsigned CW = $clog2(MAX_DIM);
   localparam int unsigned XW = ((CW > DIM_W) ? CW : DIM_W) + 2;

   logic [CW-1:0] col_ff, col_in, row_ff, row_in;
   logic [CW-1:0] col_cur, row_cur, wm1, hm1;
   logic          col_end, row_end;
   logic signed [XW-1:0] scr_x, scr_y, lim_x, lim_y;
   logic          on_screen;
   pix_type       s1_ff;

   // Last index of the bitmap, with the size saturated to 1..MAX_DIM.
   always_comb begin
      if (cfg.bitmap_width == '0) begin
         wm1 = '0;
      end else if (32'(cfg.bitmap_width) > 32'(MAX_DIM)) begin
         wm1 = CW'(MAX_DIM - 1);
      end else begin
         wm1 = CW'(cfg.bitmap_width - 13'd1);
      end
      if (cfg.bitmap_height == '0) begin
         hm1 = '0;
      end else if (32'(cfg.bitmap_height) > 32'(MAX_DIM)) begin
         hm1 = CW'(MAX_DIM - 1);
      end else begin
         hm1 = CW'(cfg.bitmap_height - 13'd1);
      end
   end

   // A first pixel starts from the origin of the bitmap.
   assign col_cur = first ? '0 : col_ff;
   assign row_cur = first ? '0 : row_ff;
   assign col_end = (col_cur >= wm1);
   assign row_end = (row_cur >= hm1);

   // Screen place; rows are stored bottom-up.
   assign scr_x = $signed({{(XW-DIM_W){cfg.pos_x[12]}}, cfg.pos_x})
                + $signed({{(XW-CW){1'b0}}, col_cur});
   assign scr_y = $signed({{(XW-DIM_W){cfg.pos_y[12]}}, cfg.pos_y})
                + $signed({{(XW-CW){1'b0}}, hm1})
                - $signed({{(XW-CW){1'b0}}, row_cur});
   assign lim_x = $signed({{(XW-DIM_W){1'b0}}, cfg.dest_width});
   assign lim_y = $signed({{(XW-DIM_W){1'b0}}, cfg.dest_height});
   assign on_screen = (scr_x >= 0) && (scr_x < lim_x) && (scr_y >= 0) && (scr_y < lim_y);

   // Counter advance on every transfer.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_cur + 1'b1;
         end else begin
            col_in = col_cur + 1'b1;
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // First pipeline stage.
   always_ff @(posedge clock) begin
      if (load) begin
         s1_ff.alpha     <= src_pixel[31:24];
         s1_ff.src_rgb   <= src_pixel[23:0];
         s1_ff.dst_rgb   <= dst_pixel[23:0];
         s1_ff.on_screen <= on_screen;
         s1_ff.last      <= col_end && row_end;
         s1_ff.scr_x     <= scr_x[12:0];
         s1_ff.scr_y     <= scr_y[12:0];
      end
   end

   assign s1 = s1_ff;

endmodule
`default_nettype wire

@@ sv/csab_chan.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite blitter channel blend
// Straight-alpha blend of one 8-bit color channel, rounded to nearest.
// ----------------------------------------------------------------------------
module csab_chan
   import csab_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       load,
   input  wire logic [7:0] alpha,
   input  wire logic [7:0] src,
   input  wire logic [7:0] dst,
   output logic      [7:0] blend
);

   logic [15:0] prod_s, prod_d, num_in, num_ff;
   logic [16:0] dividend;
   logic [33:0] scaled;

   // Weighted sum d*(255-a) + s*a.
   assign prod_s = 16'(alpha) * 16'(src);
   assign prod_d = 16'(8'hFF - alpha) * 16'(dst);
   assign num_in = prod_s + prod_d;

   always_ff @(posedge clock) begin
      if (load) begin
         num_ff <= num_in;
      end
   end

   // Divide (2*num + 255) by 510 through the reciprocal.
   assign dividend = {num_ff, 1'b0} + 17'd255;
   assign scaled   = 34'(dividend) * 34'(BLEND_RECIP);
   assign blend    = scaled[BLEND_SHIFT +: 8];

endmodule
`default_nettype wire

@@ tb/tb_clipped_alpha_sprite_blit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clipped alpha sprite blitter testbench
// Streams bitmap pixels through the blitter under a series of register
// settings and checks every result transfer against a local model of the
// walk, clip, address and blend logic. A short directed plan comes first,
// then randomized bitmaps with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_clipped_alpha_sprite_blit;
   import csab_pkg::*;

   localparam int CLK_HALF        = 6;
   localparam int RESET_CYCLES    = 11;
   localparam int BITMAP_MAX      = 4096;
   localparam int RANDOM_ITEMS    = 1750;
   localparam int CALM_ITEMS      = 150;
   localparam int PRESSURE_AT     = 400;
   localparam int PRESSURE_ITEMS  = 64;
   localparam int PRESSURE_CYCLES = 200;
   localparam int IDLE_LIMIT      = 4000;
   localparam int DRAIN_CYCLES    = 10;
   localparam int REPORT_LIMIT    = 10;

   // Register index with no register behind it; writes to it are ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 3'd7;

   // One result of the blitter.
   typedef struct packed {
      logic        write_enable;
      logic [27:0] dest_address;
      logic [23:0] blended_color;
      logic        last;
   } pixel_write_type;

   // One row of the directed plan: either a register write or a pixel.
   typedef struct packed {
      logic                   is_reg;
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0]  reg_value;
      logic [31:0]            src_pixel;
      logic [31:0]            dst_pixel;
      logic                   first;
      logic                   typed;
      pixel_write_type        want;
   } plan_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic [63:0]            req_tdata;
   logic                   req_tuser;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Local copy of the registers and of the bitmap walk counters.
   cfg_type      shadow;
   int           walk_col;
   int           walk_row;

   pixel_write_type pending_writes[$];
   plan_row_type    plan[$];
   int              bad_count;
   int              results_seen;
   int              items_sent;
   int              idle_cycles;
   int              gap_pct;
   bit              calm;
   bit              squeeze;

   clipped_alpha_sprite_blit #(
      .MAX_DIM(BITMAP_MAX)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_HALF) clock = ~clock;

   // Bitmap sizes are used saturated to 1..BITMAP_MAX.
   function automatic int unsigned clamp_dim(logic [12:0] v);
      if (v == 0) return 1;
      if (v > BITMAP_MAX) return BITMAP_MAX;
      return v;
   endfunction

   // Straight-alpha blend of one channel, rounded half up.
   function automatic logic [7:0] mix_channel(logic [7:0] s, logic [7:0] d, logic [7:0] a);
      int unsigned num;
      num = int'(d) * (255 - int'(a)) + int'(s) * int'(a);
      return 8'((2 * num + 255) / 510);
   endfunction

   // Maps the pixel at the current walk position to the screen, clips it,
   // blends it and advances the walk.
   function automatic pixel_write_type place_and_blend(logic [31:0] src, logic [31:0] dst,
                                                       logic first);
      int unsigned     w;
      int unsigned     h;
      longint          sx;
      longint          sy;
      longint          addr;
      bit              col_end;
      bit              row_end;
      pixel_write_type r;
      w = clamp_dim(shadow.bitmap_width);
      h = clamp_dim(shadow.bitmap_height);
      if (first) begin
         walk_col = 0;
         walk_row = 0;
      end
      // Storage rows run bottom-up, so row 0 lands on the lowest screen row.
      sx = longint'($signed(shadow.pos_x)) + walk_col;
      sy = longint'($signed(shadow.pos_y)) + longint'(h) - 1 - walk_row;
      r = '0;
      r.write_enable = sx >= 0 && sx < longint'(shadow.dest_width) &&
                       sy >= 0 && sy < longint'(shadow.dest_height);
      if (r.write_enable) begin
         addr = sy * longint'(shadow.dest_pitch) + sx * longint'(BYTES_PER_PIXEL);
         r.dest_address  = addr[27:0];
         r.blended_color = {mix_channel(src[23:16], dst[23:16], src[31:24]),
                            mix_channel(src[15:8], dst[15:8], src[31:24]),
                            mix_channel(src[7:0], dst[7:0], src[31:24])};
      end
      // A counter at or past its last index wraps, even after a size change.
      col_end = walk_col >= w - 1;
      row_end = walk_row >= h - 1;
      r.last  = col_end && row_end;
      if (col_end) begin
         walk_col = 0;
         walk_row = row_end ? 0 : walk_row + 1;
      end else begin
         walk_col++;
      end
      return r;
   endfunction

   // Mirrors a register write into the local copy.
   function automatic void apply_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_DEST_WIDTH:    shadow.dest_width    = val[12:0];
         CSR_DEST_HEIGHT:   shadow.dest_height   = val[12:0];
         CSR_DEST_PITCH:    shadow.dest_pitch    = val;
         CSR_BITMAP_WIDTH:  shadow.bitmap_width  = val[12:0];
         CSR_BITMAP_HEIGHT: shadow.bitmap_height = val[12:0];
         CSR_POS_X:         shadow.pos_x         = val[12:0];
         CSR_POS_Y:         shadow.pos_y         = val[12:0];
         default: ;
      endcase
   endfunction

   // Destination sizes: mostly small so that bitmaps clip at the edges.
   function automatic logic [CSR_DATA_W-1:0] pick_extent();
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 3))
               0:       return 17'd0;
               1:       return 17'd1;
               2:       return 17'd4096;
               default: return 17'd8191;
            endcase
         end
         1:       return 17'($urandom_range(0, 8191));
         default: return 17'($urandom_range(1, 24));
      endcase
   endfunction

   // Bitmap sizes: mostly small, sometimes zero or at or past the maximum.
   function automatic logic [CSR_DATA_W-1:0] pick_size();
      case ($urandom_range(0, 19))
         0, 1:    return 17'd0;
         2:       return 17'($urandom_range(4096, 8191));
         default: return 17'($urandom_range(1, 8));
      endcase
   endfunction

   // Screen positions: mostly near the origin, sometimes anywhere.
   function automatic logic [CSR_DATA_W-1:0] pick_pos();
      case ($urandom_range(0, 7))
         0:       return 17'h1000;
         1:       return 17'h0FFF;
         2:       return 17'(13'($urandom));
         default: return 17'(13'($urandom_range(0, 40) - 16));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_pitch();
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 2))
               0:       return 17'd0;
               1:       return 17'd4;
               default: return 17'h1FFFF;
            endcase
         end
         1:       return 17'($urandom);
         default: return 17'($urandom_range(1, 40) * 4);
      endcase
   endfunction

   task automatic add_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      plan_row_type r;
      r           = '0;
      r.is_reg    = 1'b1;
      r.reg_index = idx;
      r.reg_value = val;
      plan.push_back(r);
   endtask

   task automatic add_pix(logic [31:0] src, logic [31:0] dst, logic first);
      plan_row_type r;
      r           = '0;
      r.src_pixel = src;
      r.dst_pixel = dst;
      r.first     = first;
      plan.push_back(r);
   endtask

   task automatic add_typed(logic [31:0] src, logic [31:0] dst, logic first,
                            pixel_write_type want);
      plan_row_type r;
      r           = '0;
      r.src_pixel = src;
      r.dst_pixel = dst;
      r.first     = first;
      r.typed     = 1'b1;
      r.want      = want;
      plan.push_back(r);
   endtask

   // Register write; csr_valid stays high until the caller lowers it.
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, val);
   endtask

   // Offers one pixel, possibly after an idle burst, and records its result.
   task automatic send_pixel(logic [31:0] src, logic [31:0] dst, logic first);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tdata  <= {dst, src};
      req_tuser  <= first;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_writes.push_back(place_and_blend(src, dst, first));
      items_sent++;
   endtask

   // Stops offering pixels and waits until every result has arrived.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
   endtask

   task automatic flag(string what, longint unsigned want, longint unsigned got);
      bad_count++;
      if (bad_count <= REPORT_LIMIT)
         $display("result %0d: %s expected 0x%0h, got 0x%0h", results_seen, what, want, got);
   endtask

   // Stimulus: directed plan, then random bitmaps, then a calm tail.
   initial begin : stimulus
      plan_row_type row;
      int unsigned  bw;
      int unsigned  bh;
      int           count;
      bit           is_big;
      bit           fresh;
      logic         first;
      logic [7:0]   alpha;
      reset      <= 1'b1;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      req_tvalid <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      shadow.dest_width    = DEST_WIDTH_RST;
      shadow.dest_height   = DEST_HEIGHT_RST;
      shadow.dest_pitch    = DEST_PITCH_RST;
      shadow.bitmap_width  = BITMAP_WIDTH_RST;
      shadow.bitmap_height = BITMAP_HEIGHT_RST;
      shadow.pos_x         = '0;
      shadow.pos_y         = '0;
      walk_col     = 0;
      walk_row     = 0;
      bad_count    = 0;
      items_sent   = 0;
      gap_pct      = 20;
      calm         = 1'b0;
      squeeze      = 1'b0;

      // Reset settings: 64x64 bitmap at the origin, first pixel on row 63.
      add_typed(32'h00FF_FFFF, 32'h0000_0000, 1'b1, {1'b1, 28'd161280, 24'h000000, 1'b0});
      add_typed(32'hFF12_3456, 32'h00AB_CDEF, 1'b0, {1'b1, 28'd161284, 24'h123456, 1'b0});
      add_pix(32'h80FF_FFFF, 32'h0000_0000, 1'b0);
      add_typed(32'hFFFF_FFFF, 32'h0000_0000, 1'b0, {1'b1, 28'd161292, 24'hFFFFFF, 1'b0});
      add_typed(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, {1'b1, 28'd161296, 24'hFFFFFF, 1'b0});
      add_pix(32'h01FF_00FF, 32'hFF00_FF00, 1'b0);
      add_pix(32'h7F80_40C0, 32'h3355_AA66, 1'b0);
      // Zero bitmap size shrinks the bitmap to one pixel mid-walk.
      add_reg(CSR_BITMAP_WIDTH, 17'd0);
      add_reg(CSR_BITMAP_HEIGHT, 17'd0);
      add_reg(CSR_SPARE, 17'h1FFFF);
      add_pix(32'hC0A0_B0C0, 32'h1020_3040, 1'b0);
      add_pix(32'h4011_2233, 32'hEE44_5566, 1'b0);
      // Zero destination width clips everything.
      add_reg(CSR_DEST_WIDTH, 17'd0);
      add_typed(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, {1'b0, 28'd0, 24'd0, 1'b1});
      // Largest settings: the address wraps, oversized bitmap saturates.
      add_reg(CSR_DEST_WIDTH, 17'd8191);
      add_reg(CSR_DEST_HEIGHT, 17'd8191);
      add_reg(CSR_DEST_PITCH, 17'h1FFFF);
      add_reg(CSR_BITMAP_WIDTH, 17'd8191);
      add_reg(CSR_BITMAP_HEIGHT, 17'd5000);
      add_reg(CSR_POS_X, 17'h0FFF);
      add_reg(CSR_POS_Y, 17'h0FFF);
      add_pix(32'hAA55_AA55, 32'h55AA_55AA, 1'b1);
      add_pix(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
      add_pix(32'hFE01_FE01, 32'h01FE_01FE, 1'b0);
      // Most negative position: fully clipped.
      add_reg(CSR_POS_X, 17'h1000);
      add_reg(CSR_POS_Y, 17'h1000);
      add_typed(32'hFFFF_FFFF, 32'h0000_0000, 1'b1, {1'b0, 28'd0, 24'd0, 1'b0});
      // One-pixel screen under a 2x2 bitmap raised by one row.
      add_reg(CSR_DEST_WIDTH, 17'd1);
      add_reg(CSR_DEST_HEIGHT, 17'd1);
      add_reg(CSR_DEST_PITCH, 17'd4);
      add_reg(CSR_BITMAP_WIDTH, 17'd2);
      add_reg(CSR_BITMAP_HEIGHT, 17'd2);
      add_reg(CSR_POS_X, 17'd0);
      add_reg(CSR_POS_Y, 17'h1FFF);
      add_pix(32'hFF0A_0B0C, 32'h0000_0000, 1'b1);
      add_typed(32'h8080_8080, 32'h8080_8080, 1'b0, {1'b0, 28'd0, 24'd0, 1'b0});
      add_typed(32'h8080_8080, 32'h8080_8080, 1'b0, {1'b0, 28'd0, 24'd0, 1'b0});
      add_typed(32'h8080_8080, 32'h8080_8080, 1'b0, {1'b0, 28'd0, 24'd0, 1'b1});
      add_pix(32'h9988_7766, 32'h1122_3344, 1'b0);
      add_pix(32'h2233_4455, 32'hDDCC_BBAA, 1'b1);
      add_pix(32'h6677_8899, 32'h0F0F_0F0F, 1'b0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed plan.
      foreach (plan[i]) begin
         row = plan[i];
         if (row.is_reg) begin
            drain();
            write_reg(row.reg_index, row.reg_value);
         end else begin
            csr_valid <= 1'b0;
            send_pixel(row.src_pixel, row.dst_pixel, row.first);
            if (row.typed)
               pending_writes[pending_writes.size() - 1] = row.want;
         end
      end

      // Random phases: new settings, then whole bitmaps (short runs of big ones) with some noise.
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent >= RANDOM_ITEMS - CALM_ITEMS)
            calm = 1'b1;
         drain();
         write_reg(CSR_DEST_WIDTH, pick_extent());
         write_reg(CSR_DEST_HEIGHT, pick_extent());
         write_reg(CSR_DEST_PITCH, pick_pitch());
         write_reg(CSR_BITMAP_WIDTH, pick_size());
         write_reg(CSR_BITMAP_HEIGHT, pick_size());
         write_reg(CSR_POS_X, pick_pos());
         write_reg(CSR_POS_Y, pick_pos());
         csr_valid <= 1'b0;
         case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 10;
            default: gap_pct = 35;
         endcase
         bw     = clamp_dim(shadow.bitmap_width);
         bh     = clamp_dim(shadow.bitmap_height);
         is_big = bw * bh > 256;
         count  = is_big ? $urandom_range(4, 40) : bw * bh * $urandom_range(1, 3);
         // One long phase keeps offering pixels through the receiver's hold-off.
         if (!squeeze && items_sent >= PRESSURE_AT) begin
            squeeze = 1'b1;
            count   = PRESSURE_ITEMS;
         end
         // Some phases continue the previous walk under the new sizes.
         fresh  = $urandom_range(0, 3) != 0;
         for (int k = 0; k < count; k++) begin
            first = (k == 0 && fresh) || ($urandom_range(0, 40) == 0);
            case ($urandom_range(0, 3))
               0:       alpha = 8'h00;
               1:       alpha = 8'hFF;
               default: alpha = 8'($urandom);
            endcase
            send_pixel({alpha, 24'($urandom)}, $urandom, first);
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (bad_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Result side readiness: short random stalls, one long hold-off.
   initial begin : rsp_side
      bit pressure_done;
      pressure_done = 1'b0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!pressure_done && squeeze) begin
            pressure_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // Compare each result transfer with the oldest pending write.
   initial results_seen = 0;
   always @(posedge clock) begin : rsp_check
      pixel_write_type got;
      pixel_write_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.write_enable  = rsp_tuser;
         got.dest_address  = rsp_tdata[27:0];
         got.blended_color = rsp_tdata[51:28];
         got.last          = rsp_tlast;
         results_seen++;
         if (pending_writes.size() == 0) begin
            flag("result with nothing pending", 0, got);
         end else begin
            want = pending_writes.pop_front();
            if (got.write_enable !== want.write_enable)
               flag("write_enable", want.write_enable, got.write_enable);
            if (got.dest_address !== want.dest_address)
               flag("dest_address", want.dest_address, got.dest_address);
            if (got.blended_color !== want.blended_color)
               flag("blended_color", want.blended_color, got.blended_color);
            if (got.last !== want.last)
               flag("last", want.last, got.last);
         end
      end
   end

   // Watchdog: ends the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

endmodule

@@ clipped_alpha_sprite_blit.f @@
sv/csab_pkg.sv
sv/csab_cfg.sv
sv/csab_walk.sv
sv/csab_chan.sv
sv/clipped_alpha_sprite_blit.sv
tb/tb_clipped_alpha_sprite_blit.sv
